[rtl/mlps_pkg.sv]
// ----------------------------------------------------------------------------
// mlps_pkg
// Shared types and constants of the looping MIDI pattern sequencer.
// ----------------------------------------------------------------------------
package mlps_pkg;

   // Item codes of the request channel.
   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_APPEND = 3'd1;
   localparam logic [2:0] OP_TICK   = 3'd2;
   localparam logic [2:0] OP_FLUSH  = 3'd3;
   localparam logic [2:0] OP_DROP   = 3'd4;

   // Upper nibbles of note messages.
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

   // Held-note bitmap: 2048 keys kept as 64 rows of 32 bits.
   localparam int ROWS  = 64;
   localparam int ROW_W = 6;
   localparam int BIT_W = 5;
   localparam int KEY_W = 11;
   localparam int KEYS  = 2048;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] event_tick;
      logic [7:0]  status_byte;
      logic [6:0]  data_one;
      logic [6:0]  data_two;
      logic [1:0]  part;
   } req_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic [7:0]  out_status;
      logic [6:0]  out_data_one;
      logic [6:0]  out_data_two;
      logic [1:0]  out_part;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tick;
      logic [7:0]  st;
      logic [6:0]  d1;
      logic [6:0]  d2;
      logic [1:0]  part;
   } event_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AP_RD,
      ST_AP_CMP,
      ST_TK_RD,
      ST_TK_CHK,
      ST_TK_EMIT,
      ST_TK_TRK,
      ST_TK_END,
      ST_REL_ROW,
      ST_REL_LD,
      ST_REL_BIT,
      ST_REL_EMIT,
      ST_REL_DONE,
      ST_FINISH
   } state_type;

endpackage

[rtl/mlps_ram.sv]
// ----------------------------------------------------------------------------
// mlps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mlps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [ADDR_W-1:0]       waddr,
   input  logic [WIDTH-1:0]        wdata,
   input  logic [ADDR_W-1:0]       raddr,
   output logic [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/midi_loop_pattern_sequencer_core.sv]
// ----------------------------------------------------------------------------
// midi_loop_pattern_sequencer_core
// Loops a sorted table of timed MIDI events and tracks held notes.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    mlps_pkg::req_type
//   rsp_     out        rsp_valid/stall    mlps_pkg::rsp_type
//   csr_     in         csr_valid/ready    loop_length, 16 bits
//
// An append reads and compares each table entry it moves past, moving later
// entries up one slot. A tick reads each table slot and checks its tick; a
// matching event is staged for output, and a note message also updates the
// held-note bitmap. A seam or a flush sweeps the 64 rows of the held-note
// bitmap RAM in order, loading each occupied row and releasing its notes.
// Reset is synchronous and needs no clearing pass: row valid bits clear the
// bitmap at once. Output stalls hold the sequencer in place.
// ----------------------------------------------------------------------------
module midi_loop_pattern_sequencer_core #(
   parameter int EVENT_SLOTS = 32,
   parameter int HELD_MAX    = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mlps_pkg::req_type  req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mlps_pkg::rsp_type  rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data
);

   localparam int SLOT_AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int CW      = $clog2(EVENT_SLOTS + 1);
   localparam int HW      = $clog2(HELD_MAX + 1);
   localparam int EV_W    = $bits(mlps_pkg::event_type);

   mlps_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [HW-1:0]       held_ff, held_in;
   logic [15:0]         phase_ff, phase_in;
   logic [31:0]         time_ff, time_in;
   logic [15:0]         len_ff;
   logic [31:0]         stamp_ff, stamp_in;
   logic [mlps_pkg::ROWS-1:0]  rowv_ff, rowv_in;
   logic [mlps_pkg::ROW_W-1:0] row_ff, row_in;
   logic [31:0]         word_ff, word_in;
   logic [mlps_pkg::BIT_W-1:0] bit_ff, bit_in;
   mlps_pkg::event_type new_ff, new_in;
   mlps_pkg::event_type cur_ff, cur_in;
   logic                pend_v_ff, pend_v_in;
   mlps_pkg::rsp_type   pend_ff, pend_in;
   logic                out_v_ff, out_v_in;
   mlps_pkg::rsp_type   out_ff, out_in;

   // RAM ports.
   logic                ev_we;
   logic [SLOT_AW-1:0]  ev_waddr, ev_raddr;
   mlps_pkg::event_type ev_wdata, ev_rdata;
   logic                mk_we;
   logic [mlps_pkg::ROW_W-1:0] mk_waddr, mk_raddr;
   logic [31:0]         mk_wdata, mk_rdata;
   logic                pt_we;
   logic [mlps_pkg::KEY_W-1:0] pt_waddr;
   logic [1:0]          pt_wdata, pt_rdata;

   logic                accept;
   logic                slot_free;
   logic [mlps_pkg::KEY_W-1:0] cur_key;
   logic [31:0]         row_word;
   logic [16:0]         phase_nx;
   logic [mlps_pkg::BIT_W-1:0] low_bit;

   mlps_ram #(.WIDTH(EV_W), .DEPTH(EVENT_SLOTS)) u_event_ram (
      .clock (clock),
      .we    (ev_we),
      .waddr (ev_waddr),
      .wdata (ev_wdata),
      .raddr (ev_raddr),
      .rdata (ev_rdata)
   );

   mlps_ram #(.WIDTH(32), .DEPTH(mlps_pkg::ROWS)) u_mask_ram (
      .clock (clock),
      .we    (mk_we),
      .waddr (mk_waddr),
      .wdata (mk_wdata),
      .raddr (mk_raddr),
      .rdata (mk_rdata)
   );

   // The part of the next released note is read as its bit is picked.
   mlps_ram #(.WIDTH(2), .DEPTH(mlps_pkg::KEYS)) u_part_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (pt_waddr),
      .wdata (pt_wdata),
      .raddr ({row_ff, bit_in}),
      .rdata (pt_rdata)
   );

   // Lowest set bit of the current bitmap row.
   always_comb begin
      low_bit = '0;
      for (int i = 31; i >= 0; i--) begin
         if (word_ff[i]) begin
            low_bit = mlps_pkg::BIT_W'(i);
         end
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != mlps_pkg::ST_IDLE);
   assign slot_free = !out_v_ff || !rsp_stall;
   assign cur_key   = {cur_ff.st[3:0], cur_ff.d1};
   assign row_word  = rowv_ff[cur_key[10:5]] ? mk_rdata : 32'd0;
   assign phase_nx  = {1'b0, phase_ff} + 17'd1;
   assign csr_ready = 1'b1;

   // Sequencer: next state, RAM accesses and result staging.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      held_in   = held_ff;
      phase_in  = phase_ff;
      time_in   = time_ff;
      stamp_in  = stamp_ff;
      rowv_in   = rowv_ff;
      row_in    = row_ff;
      word_in   = word_ff;
      bit_in    = bit_ff;
      new_in    = new_ff;
      cur_in    = cur_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      out_v_in  = out_v_ff && rsp_stall;
      out_in    = out_ff;
      ev_we     = 1'b0;
      ev_waddr  = SLOT_AW'(idx_ff);
      ev_wdata  = new_ff;
      ev_raddr  = SLOT_AW'(idx_ff);
      mk_we     = 1'b0;
      mk_waddr  = cur_key[10:5];
      mk_wdata  = row_word;
      mk_raddr  = row_ff;
      pt_we     = 1'b0;
      pt_waddr  = cur_key;
      pt_wdata  = cur_ff.part;

      unique case (state_ff)
         mlps_pkg::ST_IDLE: begin
            if (accept) begin
               new_in = '{tick: req_item.event_tick, st: req_item.status_byte,
                          d1: req_item.data_one, d2: req_item.data_two,
                          part: req_item.part};
               idx_in = '0;
               row_in = '0;
               state_in = mlps_pkg::ST_FINISH;
               unique case (req_item.op)
                  mlps_pkg::OP_CLEAR: begin
                     cnt_in  = '0;
                     rowv_in = '0;
                     held_in = '0;
                  end
                  mlps_pkg::OP_APPEND: begin
                     if (cnt_ff < CW'(EVENT_SLOTS)) begin
                        idx_in   = cnt_ff;
                        state_in = mlps_pkg::ST_AP_RD;
                     end
                  end
                  mlps_pkg::OP_TICK: begin
                     if (len_ff != 16'd0) begin
                        if (phase_ff >= len_ff) begin
                           phase_in = 16'd0;
                        end
                        state_in = mlps_pkg::ST_TK_RD;
                     end
                  end
                  mlps_pkg::OP_FLUSH: begin
                     stamp_in = time_ff;
                     state_in = mlps_pkg::ST_REL_ROW;
                  end
                  mlps_pkg::OP_DROP: begin
                     rowv_in = '0;
                     held_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Insertion: move later-tick entries up one slot.
         mlps_pkg::ST_AP_RD: begin
            ev_raddr = SLOT_AW'(idx_ff - CW'(1));
            if (idx_ff == '0) begin
               ev_we    = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
               state_in = mlps_pkg::ST_FINISH;
            end else begin
               state_in = mlps_pkg::ST_AP_CMP;
            end
         end
         mlps_pkg::ST_AP_CMP: begin
            ev_we = 1'b1;
            if (ev_rdata.tick > new_ff.tick) begin
               ev_wdata = ev_rdata;
               idx_in   = idx_ff - CW'(1);
               state_in = mlps_pkg::ST_AP_RD;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = mlps_pkg::ST_FINISH;
            end
         end

         // Tick scan over the table.
         mlps_pkg::ST_TK_RD: begin
            if (idx_ff >= cnt_ff) begin
               state_in = mlps_pkg::ST_TK_END;
            end else begin
               state_in = mlps_pkg::ST_TK_CHK;
            end
         end
         mlps_pkg::ST_TK_CHK: begin
            cur_in = ev_rdata;
            if (ev_rdata.tick == phase_ff) begin
               state_in = mlps_pkg::ST_TK_EMIT;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = mlps_pkg::ST_TK_RD;
            end
         end
         mlps_pkg::ST_TK_EMIT: begin
            mk_raddr = cur_key[10:5];
            if (!pend_v_ff || slot_free) begin
               if (pend_v_ff) begin
                  out_v_in = 1'b1;
                  out_in   = pend_ff;
               end
               pend_v_in = 1'b1;
               pend_in   = '{stamp: time_ff, out_status: cur_ff.st,
                             out_data_one: cur_ff.d1, out_data_two: cur_ff.d2,
                             out_part: cur_ff.part, last: 1'b0};
               if (cur_ff.st[7:4] == mlps_pkg::KIND_NOTE_ON ||
                   cur_ff.st[7:4] == mlps_pkg::KIND_NOTE_OFF) begin
                  state_in = mlps_pkg::ST_TK_TRK;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = mlps_pkg::ST_TK_RD;
               end
            end
         end
         mlps_pkg::ST_TK_TRK: begin
            idx_in   = idx_ff + CW'(1);
            state_in = mlps_pkg::ST_TK_RD;
            if (cur_ff.st[7:4] == mlps_pkg::KIND_NOTE_ON && cur_ff.d2 != 7'd0) begin
               if (row_word[cur_key[4:0]]) begin
                  pt_we = 1'b1;
               end else if (held_ff < HW'(HELD_MAX)) begin
                  pt_we    = 1'b1;
                  mk_we    = 1'b1;
                  mk_wdata = row_word | (32'd1 << cur_key[4:0]);
                  rowv_in[cur_key[10:5]] = 1'b1;
                  held_in  = held_ff + HW'(1);
               end
            end else if (row_word[cur_key[4:0]]) begin
               mk_we    = 1'b1;
               mk_wdata = row_word & ~(32'd1 << cur_key[4:0]);
               rowv_in[cur_key[10:5]] = 1'b1;
               held_in  = held_ff - HW'(1);
            end
         end
         mlps_pkg::ST_TK_END: begin
            time_in = time_ff + 32'd1;
            if (phase_nx >= {1'b0, len_ff}) begin
               phase_in = 16'd0;
               stamp_in = time_ff + 32'd1;
               row_in   = '0;
               state_in = mlps_pkg::ST_REL_ROW;
            end else begin
               phase_in = phase_nx[15:0];
               state_in = mlps_pkg::ST_FINISH;
            end
         end

         // Release sweep over the bitmap rows in ascending key order.
         mlps_pkg::ST_REL_ROW: begin
            if (rowv_ff[row_ff]) begin
               state_in = mlps_pkg::ST_REL_LD;
            end else if (row_ff == mlps_pkg::ROW_W'(mlps_pkg::ROWS - 1)) begin
               state_in = mlps_pkg::ST_REL_DONE;
            end else begin
               row_in = row_ff + mlps_pkg::ROW_W'(1);
            end
         end
         mlps_pkg::ST_REL_LD: begin
            word_in  = mk_rdata;
            state_in = mlps_pkg::ST_REL_BIT;
         end
         mlps_pkg::ST_REL_BIT: begin
            if (word_ff == 32'd0) begin
               if (row_ff == mlps_pkg::ROW_W'(mlps_pkg::ROWS - 1)) begin
                  state_in = mlps_pkg::ST_REL_DONE;
               end else begin
                  row_in   = row_ff + mlps_pkg::ROW_W'(1);
                  state_in = mlps_pkg::ST_REL_ROW;
               end
            end else begin
               bit_in   = low_bit;
               word_in  = word_ff & ~(32'd1 << low_bit);
               state_in = mlps_pkg::ST_REL_EMIT;
            end
         end
         mlps_pkg::ST_REL_EMIT: begin
            if (!pend_v_ff || slot_free) begin
               if (pend_v_ff) begin
                  out_v_in = 1'b1;
                  out_in   = pend_ff;
               end
               pend_v_in = 1'b1;
               pend_in   = '{stamp: stamp_ff,
                             out_status: {mlps_pkg::KIND_NOTE_OFF, row_ff[5:2]},
                             out_data_one: {row_ff[1:0], bit_ff},
                             out_data_two: 7'd0, out_part: pt_rdata,
                             last: 1'b0};
               state_in  = mlps_pkg::ST_REL_BIT;
            end
         end
         mlps_pkg::ST_REL_DONE: begin
            rowv_in  = '0;
            held_in  = '0;
            state_in = mlps_pkg::ST_FINISH;
         end

         // Hand out the staged result marked as the item's last one.
         mlps_pkg::ST_FINISH: begin
            if (!pend_v_ff) begin
               state_in = mlps_pkg::ST_IDLE;
            end else if (slot_free) begin
               out_v_in      = 1'b1;
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               pend_v_in     = 1'b0;
               state_in      = mlps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlps_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mlps_pkg::ST_IDLE;
         cnt_ff    <= '0;
         held_ff   <= '0;
         phase_ff  <= '0;
         time_ff   <= '0;
         rowv_ff   <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         len_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         held_ff   <= held_in;
         phase_ff  <= phase_in;
         time_ff   <= time_in;
         rowv_ff   <= rowv_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
         if (csr_valid && csr_ready) begin
            len_ff <= csr_data;
         end
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      stamp_ff <= stamp_in;
      row_ff   <= row_in;
      word_ff  <= word_in;
      bit_ff   <= bit_in;
      new_ff   <= new_in;
      cur_ff   <= cur_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;

`ifndef SYNTHESIS
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlps_pkg::ST_IDLE |-> !pend_v_ff)
      else $error("staged result left behind at item end");
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(HELD_MAX))
      else $error("held note count exceeds limit");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(EVENT_SLOTS))
      else $error("event count exceeds table size");
`endif

endmodule

[tb/sv/midi_loop_pattern_sequencer_core_test.sv]
// ----------------------------------------------------------------------------
// midi_loop_pattern_sequencer_core_test
// Drives load, tick, flush, drop and clear items into the sequencer core with
// random gaps and output stalls, predicts every emitted message and held-note
// release, and compares each result item field by field in order.
// ----------------------------------------------------------------------------
class sequencer_scoreboard;
   // Predicted copy of the block state.
   mlps_pkg::event_type table_q[$];
   bit         held[mlps_pkg::KEYS];
   logic [1:0] held_tag[mlps_pkg::KEYS];
   int         held_num;
   logic [15:0] phase;
   logic [31:0] now;
   logic [15:0] length;
   mlps_pkg::rsp_type pending[$];
   int         errors;

   function void reset_state();
      table_q.delete();
      foreach (held[k]) held[k] = 0;
      held_num = 0;
      phase = 0;
      now = 0;
      length = 0;
      pending.delete();
      errors = 0;
   endfunction

   function void push_msg(logic [31:0] st, logic [7:0] s, logic [6:0] a,
                          logic [6:0] b, logic [1:0] p);
      mlps_pkg::rsp_type r;
      r.stamp = st;
      r.out_status = s;
      r.out_data_one = a;
      r.out_data_two = b;
      r.out_part = p;
      r.last = 0;
      pending.insert(pending.size(), r);
   endfunction

   function void forget_held();
      foreach (held[k]) held[k] = 0;
      held_num = 0;
   endfunction

   // Emit note-offs for all held notes in key order, then clear them.
   function void release_held(logic [31:0] st);
      for (int k = 0; k < mlps_pkg::KEYS; k++)
         if (held[k])
            push_msg(st, 8'(8'h80 | (k >> 7)), k[6:0], 7'd0, held_tag[k]);
      forget_held();
   endfunction

   function void follow_note(mlps_pkg::event_type e);
      int key;
      key = {e.st[3:0], e.d1};
      if (e.st[7:4] == mlps_pkg::KIND_NOTE_ON && e.d2 != 0) begin
         if (held[key]) begin
            held_tag[key] = e.part;
         end else if (held_num < 32) begin
            held[key] = 1;
            held_tag[key] = e.part;
            held_num++;
         end
      end else if (e.st[7:4] == mlps_pkg::KIND_NOTE_OFF ||
                   e.st[7:4] == mlps_pkg::KIND_NOTE_ON) begin
         if (held[key]) begin
            held[key] = 0;
            held_num--;
         end
      end
   endfunction

   // Note an accepted input item and queue the results it causes.
   function void note_input(mlps_pkg::req_type q);
      int before_n;
      int pos;
      mlps_pkg::event_type e;
      before_n = pending.size();
      case (q.op)
         mlps_pkg::OP_CLEAR: begin
            table_q.delete();
            forget_held();
         end
         mlps_pkg::OP_APPEND: begin
            if (table_q.size() < 32) begin
               e.tick = q.event_tick;
               e.st = q.status_byte;
               e.d1 = q.data_one;
               e.d2 = q.data_two;
               e.part = q.part;
               pos = table_q.size();
               while (pos > 0 && table_q[pos-1].tick > e.tick) pos--;
               table_q.insert(pos, e);
            end
         end
         mlps_pkg::OP_TICK: begin
            if (length != 0) begin
               if (phase >= length) phase = 0;
               foreach (table_q[i])
                  if (table_q[i].tick == phase) begin
                     push_msg(now, table_q[i].st, table_q[i].d1, table_q[i].d2,
                              table_q[i].part);
                     follow_note(table_q[i]);
                  end
               phase++;
               now++;
               if (phase >= length) begin
                  phase = 0;
                  release_held(now);
               end
            end
         end
         mlps_pkg::OP_FLUSH: release_held(now);
         mlps_pkg::OP_DROP: forget_held();
         default: ;
      endcase
      if (pending.size() > before_n) pending[pending.size()-1].last = 1;
   endfunction

   function void check_result(mlps_pkg::rsp_type got);
      mlps_pkg::rsp_type want;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result item %p", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10) $display("result mismatch: expected %p, actual %p", want, got);
      end
   endfunction
endclass

module midi_loop_pattern_sequencer_core_test;
   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   mlps_pkg::req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   mlps_pkg::rsp_type rsp_item;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [15:0] csr_data = 0;

   sequencer_scoreboard board;
   int  idle_cycles = 0;
   bit  hold_rsp = 0;
   bit  stimulus_done = 0;

   midi_loop_pattern_sequencer_core uut (.*);

   always #6 clock = ~clock;

   // Watch the request and result channels: feed accepted items to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_input(req_item);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_item);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles without progress.
   always @(posedge clock) begin
      if (idle_cycles > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver stalls at random unless a long hold-off is active.
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1;
      else if (stimulus_done && $urandom_range(0, 3) == 0) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 99) < 25);
   end

   // Valid drops only over a gap, so back-to-back items keep it high.
   task automatic send_item(mlps_pkg::req_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_item <= q;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_length(logic [15:0] v);
      req_valid <= 0;
      csr_data <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      board.length = v;
   endtask

   function automatic mlps_pkg::req_type make_item(logic [2:0] op, logic [15:0] t,
                                                   logic [7:0] s, logic [6:0] a,
                                                   logic [6:0] b, logic [1:0] p);
      mlps_pkg::req_type q;
      q.op = op;
      q.event_tick = t;
      q.status_byte = s;
      q.data_one = a;
      q.data_two = b;
      q.part = p;
      return q;
   endfunction

   function automatic mlps_pkg::req_type random_note(int span);
      logic [7:0] s;
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) s = {mlps_pkg::KIND_NOTE_ON, 4'($urandom_range(0, 15))};
      else if (r < 8) s = {mlps_pkg::KIND_NOTE_OFF, 4'($urandom_range(0, 15))};
      else s = 8'($urandom_range(0, 255));
      return make_item(mlps_pkg::OP_APPEND, 16'($urandom_range(0, span)), s,
                       7'($urandom_range(0, 127)),
                       ($urandom_range(0, 5) == 0) ? 7'd0 : 7'($urandom_range(0, 127)),
                       2'($urandom_range(0, 3)));
   endfunction

   task automatic directed_phase();
      write_length(16'd4);
      // Field extremes, ties in load order and a note-on of zero velocity.
      send_item(make_item(mlps_pkg::OP_APPEND, 16'd2, 8'h9F, 7'd127, 7'd127, 2'd3));
      send_item(make_item(mlps_pkg::OP_APPEND, 16'd0, 8'h90, 7'd0, 7'd1, 2'd0));
      send_item(make_item(mlps_pkg::OP_APPEND, 16'd2, 8'h9F, 7'd127, 7'd0, 2'd1));
      send_item(make_item(mlps_pkg::OP_APPEND, 16'd1, 8'h91, 7'd5, 7'd64, 2'd2));
      send_item(make_item(mlps_pkg::OP_APPEND, 16'hFFFF, 8'hFF, 7'd127, 7'd127, 2'd3));
      send_item(make_item(mlps_pkg::OP_APPEND, 16'd1, 8'hB0, 7'd7, 7'd100, 2'd1));
      repeat (5) send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
      send_item(make_item(mlps_pkg::OP_FLUSH, '0, '0, '0, '0, '0));
      send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
      send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
      send_item(make_item(mlps_pkg::OP_DROP, '0, '0, '0, '0, '0));
      send_item(make_item(mlps_pkg::OP_FLUSH, '0, '0, '0, '0, '0));
      send_item(make_item(3'd5, 16'hFFFF, 8'hFF, 7'd127, 7'd127, 2'd3));
      send_item(make_item(3'd7, '0, '0, '0, '0, '0));
      send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
      wait_drained();
      // A lowered loop length of one: the tick wraps back to phase zero.
      write_length(16'd1);
      send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
      wait_drained();
      // Zero length: ticks do nothing.
      write_length(16'd0);
      send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
      send_item(make_item(mlps_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
      wait_drained();
   endtask

   // Fill the table past its capacity with note-ons at tick zero, then tick.
   task automatic full_table_phase();
      write_length(16'hFFFF);
      for (int i = 0; i < 34; i++)
         send_item(make_item(mlps_pkg::OP_APPEND, 16'd0, {mlps_pkg::KIND_NOTE_ON, 4'(i)},
                             7'(i * 3), 7'd90, 2'(i)));
      // Hold the receiver off while ticks pile up behind it.
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
            send_item(make_item(mlps_pkg::OP_TICK, '0, '0, '0, '0, '0));
            send_item(make_item(mlps_pkg::OP_FLUSH, '0, '0, '0, '0, '0));
         end
      join
      wait_drained();
      send_item(make_item(mlps_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
      wait_drained();
   endtask

   task automatic random_phase(logic [15:0] len, int count);
      int r;
      write_length(len);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) send_item(random_note(len + 1));
         else if (r < 85) send_item(make_item(mlps_pkg::OP_TICK, 16'($urandom),
                                              8'($urandom), 7'($urandom),
                                              7'($urandom), 2'($urandom)));
         else if (r < 90) send_item(make_item(mlps_pkg::OP_FLUSH, '0, '0, '0, '0, '0));
         else if (r < 93) send_item(make_item(mlps_pkg::OP_DROP, '0, '0, '0, '0, '0));
         else if (r < 96) send_item(make_item(mlps_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
         else send_item(make_item(3'($urandom_range(5, 7)), '0, '0, '0, '0, '0));
      end
      // The sender waits for every result before the next setting.
      wait_drained();
   endtask

   initial begin
      board = new();
      board.reset_state();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_phase();
      full_table_phase();
      random_phase(16'd3, 20);
      random_phase(16'd8, 20);
      random_phase(16'd2, 15);
      random_phase(16'd16, 15);
      stimulus_done = 1;
      wait_drained();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
